### rtl/bchd_pkg.sv
// Package for the button click and hold detector: types and constants.
`timescale 1ns / 1ps

package bchd_pkg;

  localparam int unsigned MaxClicks = 10;
  localparam logic [7:0] TickCap  = 8'hFE;
  localparam logic [7:0] HoldDone = 8'hFF;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [2:0] {
    RegShortPressLimit = 3'd0,
    RegClickTimeout    = 3'd1,
    RegClickTarget     = 3'd2,
    RegHoldOnce        = 3'd3,
    RegRepeatMax       = 3'd4,
    RegRepeatMin       = 3'd5,
    RegRepeatStep      = 3'd6,
    RegUnused          = 3'd7
  } reg_idx_e;

  localparam logic [7:0] ShortPressLimitRst = 8'd20;
  localparam logic [7:0] ClickTimeoutRst    = 8'd30;
  localparam logic [3:0] ClickTargetRst     = 4'd15;
  localparam logic       HoldOnceRst        = 1'b0;
  localparam logic [7:0] RepeatMaxRst       = 8'd100;
  localparam logic [7:0] RepeatMinRst       = 8'd10;
  localparam logic [7:0] RepeatStepRst      = 8'd10;

  typedef struct packed {
    logic [7:0] short_press_limit;
    logic [7:0] click_timeout;
    logic [3:0] click_target;
    logic       hold_once;
    logic [7:0] repeat_max;
    logic [7:0] repeat_min;
    logic [7:0] repeat_step;
  } cfg_t;

  typedef struct packed {
    logic level;
    logic changed;
  } in_item_t;

  typedef struct packed {
    logic       click_event;
    logic [3:0] click_count;
    logic       hold_event;
  } out_item_t;

endpackage

### rtl/bchd_cfg.sv
// Configuration register file with APB-style access.
`timescale 1ns / 1ps

module bchd_cfg
  import bchd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[AddrWidth-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_press_limit <= ShortPressLimitRst;
      cfg_q.click_timeout     <= ClickTimeoutRst;
      cfg_q.click_target      <= ClickTargetRst;
      cfg_q.hold_once         <= HoldOnceRst;
      cfg_q.repeat_max        <= RepeatMaxRst;
      cfg_q.repeat_min        <= RepeatMinRst;
      cfg_q.repeat_step       <= RepeatStepRst;
    end else if (wr_en) begin
      unique case (idx)
        RegShortPressLimit: cfg_q.short_press_limit <= pwdata[7:0];
        RegClickTimeout:    cfg_q.click_timeout     <= pwdata[7:0];
        RegClickTarget:     cfg_q.click_target      <= pwdata[3:0];
        RegHoldOnce:        cfg_q.hold_once         <= pwdata[0];
        RegRepeatMax:       cfg_q.repeat_max        <= pwdata[7:0];
        RegRepeatMin:       cfg_q.repeat_min        <= pwdata[7:0];
        RegRepeatStep:      cfg_q.repeat_step       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      RegShortPressLimit: prdata[7:0] = cfg_q.short_press_limit;
      RegClickTimeout:    prdata[7:0] = cfg_q.click_timeout;
      RegClickTarget:     prdata[3:0] = cfg_q.click_target;
      RegHoldOnce:        prdata[0]   = cfg_q.hold_once;
      RegRepeatMax:       prdata[7:0] = cfg_q.repeat_max;
      RegRepeatMin:       prdata[7:0] = cfg_q.repeat_min;
      RegRepeatStep:      prdata[7:0] = cfg_q.repeat_step;
      default:            prdata      = '0;
    endcase
  end

endmodule

### rtl/bchd_step.sv
// Per-tick state update: press/release timers, click tally and hold events.
`timescale 1ns / 1ps

module bchd_step
  import bchd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  logic [7:0] pressed_q, pressed_d;
  logic [7:0] released_q, released_d;
  logic [3:0] tally_q, tally_d;
  logic [7:0] period_q, period_d;

  logic [8:0] thr_sum;
  logic [7:0] thr;
  logic [8:0] floor_sum;
  logic       target_any;

  assign thr_sum    = {1'b0, cfg_i.short_press_limit} + {1'b0, cfg_i.click_timeout};
  assign thr        = (thr_sum > {1'b0, TickCap}) ? TickCap : thr_sum[7:0];
  assign floor_sum  = {1'b0, cfg_i.repeat_min} + {1'b0, cfg_i.repeat_step};
  assign target_any = cfg_i.click_target > 4'(MaxClicks);

  always_comb begin
    pressed_d  = pressed_q;
    released_d = released_q;
    tally_d    = tally_q;
    period_d   = period_q;
    res_o      = '0;

    // edges and timers
    if (item_i.changed) begin
      if (item_i.level) begin
        if (pressed_q < cfg_i.short_press_limit && tally_q < 4'(MaxClicks)) begin
          tally_d = tally_q + 4'd1;
        end
        released_d = '0;
      end else begin
        if (released_q >= thr) begin
          tally_d = '0;
        end
        pressed_d = '0;
      end
    end else if (item_i.level) begin
      if (released_q < TickCap) released_d = released_q + 8'd1;
    end else if (pressed_q < TickCap) begin
      pressed_d = pressed_q + 8'd1;
    end

    // click report
    if (released_d >= thr && tally_d != '0 &&
        (target_any || tally_d == cfg_i.click_target)) begin
      res_o.click_event = 1'b1;
      res_o.click_count = tally_d;
      tally_d           = '0;
    end

    // hold events
    if (item_i.level) begin
      period_d = cfg_i.repeat_max;
    end else if (cfg_i.hold_once) begin
      if (pressed_d != HoldDone && pressed_d >= cfg_i.repeat_max) begin
        pressed_d        = HoldDone;
        res_o.hold_event = 1'b1;
      end
    end else if (pressed_d >= period_q) begin
      pressed_d = cfg_i.short_press_limit;
      if ({1'b0, period_q} >= floor_sum) period_d = period_q - cfg_i.repeat_step;
      res_o.hold_event = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q  <= '0;
      released_q <= '0;
      tally_q    <= '0;
      period_q   <= RepeatMaxRst;
    end else if (en_i) begin
      pressed_q  <= pressed_d;
      released_q <= released_d;
      tally_q    <= tally_d;
      period_q   <= period_d;
    end
  end

endmodule

### rtl/button_click_and_hold_detector_core.sv
// Top level of the button click and hold detector.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o     | in_item_i  (level, changed)
//   out     | output    | out_valid_o / out_stall_i   | out_item_o (click_event,
//           |           |                             |   click_count, hold_event)
//   cfg     | input     | psel/penable/pwrite/pready  | paddr, pwdata, prdata
//
// One item per cycle while in_stall_o is low; the result is registered and appears in the cycle after acceptance.
// The state update and result are a single pass of logic into the output register.
// Reset loads the register defaults and clears the timers and tally.
// in_stall_o follows out_stall_i only while a result is held in the output register.
`timescale 1ns / 1ps

module button_click_and_hold_detector_core
  import bchd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  cfg_t      cfg;
  out_item_t res;
  out_item_t res_q;
  logic      valid_q;
  logic      accept;

  assign in_stall_o  = valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = valid_q;
  assign out_item_o  = res_q;

  bchd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bchd_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .item_i (in_item_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

endmodule

### verif/tb_button_click_and_hold_detector_core.sv
// Self-checking testbench for the button click and hold detector core.
`timescale 1ns / 1ps

module tb_button_click_and_hold_detector_core;
  import bchd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam out_item_t NoEvent = '0;

  typedef struct {
    logic      level;
    logic      changed;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_item_t             in_item_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_item_t            out_item_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  // predictor copy of the registers and state
  cfg_t       cfg_m;
  logic [7:0] press_cnt;
  logic [7:0] rel_cnt;
  logic [3:0] tally;
  logic [7:0] period;

  out_item_t   expected_events[$];
  out_item_t   want;
  int unsigned mismatches;
  int unsigned ticks_sent;
  int unsigned settings_cnt;
  int unsigned click_reports;
  int unsigned hold_reports;
  int unsigned cycle_cnt;
  int unsigned gap_pct;
  int unsigned stall_pct;
  logic        btn_level;

  button_click_and_hold_detector_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_events.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] report_ticks();
    logic [8:0] sum;
    sum = {1'b0, cfg_m.short_press_limit} + {1'b0, cfg_m.click_timeout};
    return (sum > {1'b0, TickCap}) ? TickCap : sum[7:0];
  endfunction

  task automatic predict_events(input in_item_t it, output out_item_t res);
    logic [7:0] thr;
    thr = report_ticks();
    res = '0;
    if (it.changed) begin
      if (it.level) begin
        if (press_cnt < cfg_m.short_press_limit && tally < MaxClicks) tally = tally + 4'd1;
        rel_cnt = '0;
      end else begin
        if (rel_cnt >= thr) tally = '0;
        press_cnt = '0;
      end
    end else if (it.level) begin
      if (rel_cnt < TickCap) rel_cnt = rel_cnt + 8'd1;
    end else if (press_cnt < TickCap) begin
      press_cnt = press_cnt + 8'd1;
    end
    if (rel_cnt >= thr && tally != 0 &&
        (cfg_m.click_target > MaxClicks || tally == cfg_m.click_target)) begin
      res.click_event = 1'b1;
      res.click_count = tally;
      tally = '0;
    end
    if (it.level) begin
      period = cfg_m.repeat_max;
    end else if (cfg_m.hold_once) begin
      if (press_cnt != HoldDone && press_cnt >= cfg_m.repeat_max) begin
        press_cnt = HoldDone;
        res.hold_event = 1'b1;
      end
    end else if (press_cnt >= period) begin
      press_cnt = cfg_m.short_press_limit;
      if ({1'b0, period} >= {1'b0, cfg_m.repeat_min} + {1'b0, cfg_m.repeat_step})
        period = period - cfg_m.repeat_step;
      res.hold_event = 1'b1;
    end
  endtask

  // result side: random stall, compare against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (out_item_o.click_event) click_reports++;
      if (out_item_o.hold_event) hold_reports++;
      if (expected_events.size() == 0) begin
        $display("%0t: result %p with nothing expected", $time, out_item_o);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        if (out_item_o.click_event !== want.click_event) begin
          $display("%0t: click_event expected %0d got %0d", $time, want.click_event,
                   out_item_o.click_event);
          mismatches++;
        end
        if (out_item_o.click_count !== want.click_count) begin
          $display("%0t: click_count expected %0d got %0d", $time, want.click_count,
                   out_item_o.click_count);
          mismatches++;
        end
        if (out_item_o.hold_event !== want.hold_event) begin
          $display("%0t: hold_event expected %0d got %0d", $time, want.hold_event,
                   out_item_o.hold_event);
          mismatches++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_tick(input in_item_t it, input bit typed = 1'b0,
                           input out_item_t typed_want = '0);
    out_item_t predicted;
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_events(it, predicted);
    expected_events.push_back(typed ? typed_want : predicted);
    ticks_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_events.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DataWidth'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegShortPressLimit: cfg_m.short_press_limit = value;
      RegClickTimeout:    cfg_m.click_timeout = value;
      RegClickTarget:     cfg_m.click_target = value[3:0];
      RegHoldOnce:        cfg_m.hold_once = value[0];
      RegRepeatMax:       cfg_m.repeat_max = value;
      RegRepeatMin:       cfg_m.repeat_min = value;
      RegRepeatStep:      cfg_m.repeat_step = value;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [7:0] spl, input logic [7:0] timeout,
                               input logic [7:0] target, input logic [7:0] once,
                               input logic [7:0] rmax, input logic [7:0] rmin,
                               input logic [7:0] rstep);
    write_reg(RegShortPressLimit, spl);
    write_reg(RegClickTimeout, timeout);
    write_reg(RegClickTarget, target);
    write_reg(RegHoldOnce, once);
    write_reg(RegRepeatMax, rmax);
    write_reg(RegRepeatMin, rmin);
    write_reg(RegRepeatStep, rstep);
    settings_cnt++;
  endtask

  // mostly short lengths, now and then anywhere up to the top of the range
  function automatic int pick_len(input int lo, input int hi);
    if ($urandom_range(9) == 0) return $urandom_range(lo, hi);
    return $urandom_range(lo, (hi < lo + 12) ? hi : lo + 12);
  endfunction

  task automatic emit(input logic lvl, input int n);
    in_item_t it;
    for (int k = 0; k < n; k++) begin
      it.level   = lvl;
      it.changed = (k == 0) && (lvl != btn_level);
      send_tick(it);
    end
    btn_level = lvl;
  endtask

  task automatic run_phase(input int n_items);
    int       stop_at;
    int       thr;
    int       spl;
    int       rmax;
    int       kind;
    int       clicks;
    in_item_t it;
    stop_at = ticks_sent + n_items;
    while (ticks_sent < stop_at) begin
      thr  = report_ticks();
      spl  = cfg_m.short_press_limit;
      rmax = cfg_m.repeat_max;
      kind = $urandom_range(99);
      if (kind < 10) begin
        it = in_item_t'($urandom_range(3));
        send_tick(it);
        btn_level = it.level;
      end else if (kind < 45) begin
        // burst of clicks, then a release long enough to report
        clicks = $urandom_range(1, 13);
        for (int c = 0; c < clicks; c++) begin
          emit(1'b0, pick_len(1, spl));
          if (c < clicks - 1) emit(1'b1, pick_len(1, thr));
          else emit(1'b1, $urandom_range(thr + 1, thr + 3));
        end
      end else begin
        if ($urandom_range(1)) emit(1'b0, pick_len(1, spl));
        else emit(1'b0, pick_len(rmax, 3 * rmax + 20));
        if ($urandom_range(3) == 0) emit(1'b1, $urandom_range(thr + 1, thr + 3));
        else emit(1'b1, pick_len(1, thr));
      end
    end
  endtask

  initial begin
    dir_row_t dir_table [20];
    in_item_t it;

    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    rst_ni      <= 1'b0;
    mismatches    = 0;
    ticks_sent    = 0;
    settings_cnt  = 0;
    click_reports = 0;
    hold_reports  = 0;
    gap_pct       = 25;
    stall_pct     = 25;
    btn_level     = 1'b1;
    cfg_m = '{short_press_limit: ShortPressLimitRst, click_timeout: ClickTimeoutRst,
              click_target: ClickTargetRst, hold_once: HoldOnceRst,
              repeat_max: RepeatMaxRst, repeat_min: RepeatMinRst,
              repeat_step: RepeatStepRst};
    press_cnt = '0;
    rel_cnt   = '0;
    tally     = '0;
    period    = RepeatMaxRst;

    // short press limit 3, report after 4 released ticks, first hold at 4
    dir_table = '{
      '{1'b1, 1'b0, 1'b1, NoEvent},
      '{1'b0, 1'b1, 1'b1, NoEvent},
      '{1'b1, 1'b1, 1'b1, NoEvent},
      '{1'b0, 1'b1, 1'b0, NoEvent},
      '{1'b1, 1'b1, 1'b0, NoEvent},
      '{1'b1, 1'b0, 1'b0, NoEvent},
      '{1'b1, 1'b0, 1'b0, NoEvent},
      '{1'b1, 1'b0, 1'b0, NoEvent},
      '{1'b1, 1'b0, 1'b1, {1'b1, 4'd2, 1'b0}},
      '{1'b0, 1'b1, 1'b0, NoEvent},
      '{1'b0, 1'b0, 1'b0, NoEvent},
      '{1'b0, 1'b0, 1'b0, NoEvent},
      '{1'b0, 1'b0, 1'b0, NoEvent},
      '{1'b0, 1'b0, 1'b1, {1'b0, 4'd0, 1'b1}},
      '{1'b0, 1'b0, 1'b0, NoEvent},
      '{1'b0, 1'b0, 1'b0, NoEvent},
      '{1'b1, 1'b1, 1'b0, NoEvent},
      '{1'b1, 1'b1, 1'b0, NoEvent},
      '{1'b0, 1'b0, 1'b0, NoEvent},
      '{1'b1, 1'b0, 1'b0, NoEvent}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_setting(8'd3, 8'd1, 8'd15, 8'd0, 8'd4, 8'd1, 8'd2);
    foreach (dir_table[i]) begin
      it.level   = dir_table[i].level;
      it.changed = dir_table[i].changed;
      send_tick(it, dir_table[i].typed, dir_table[i].want);
    end
    drain();

    apply_setting(8'd20, 8'd30, 8'd15, 8'd0, 8'd100, 8'd10, 8'd10);
    run_phase(150);
    drain();

    // back-to-back stretch, no gaps on either side
    gap_pct   = 0;
    stall_pct = 0;
    apply_setting(8'd4, 8'd3, 8'd15, 8'd0, 8'd12, 8'd2, 8'd3);
    run_phase(250);
    drain();
    gap_pct   = 25;
    stall_pct = 25;

    apply_setting(8'd1, 8'd0, 8'd3, 8'd0, 8'd1, 8'd1, 8'd0);
    run_phase(150);
    drain();

    apply_setting(8'd6, 8'd2, 8'd0, 8'd1, 8'd8, 8'd1, 8'd1);
    run_phase(150);
    drain();

    apply_setting(8'd5, 8'd4, 8'd10, 8'd0, 8'd20, 8'd5, 8'd254);
    run_phase(150);
    drain();

    apply_setting(8'd254, 8'd254, 8'd15, 8'd1, 8'd254, 8'd254, 8'd254);
    run_phase(120);
    drain();

    repeat (3) begin
      apply_setting(8'($urandom_range(1, 12)), 8'($urandom_range(0, 10)),
                    8'($urandom_range(15)), 8'($urandom_range(1)),
                    8'($urandom_range(1, 30)), 8'($urandom_range(1, 10)),
                    8'($urandom_range(0, 8)));
      run_phase(100);
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (expected_events.size() != 0) begin
      $display("%0t: expected no outstanding results, got %0d", $time,
               expected_events.size());
      mismatches++;
    end

    $display("Sent %0d button ticks under %0d register settings, with gaps and stalls.",
             ticks_sent, settings_cnt);
    $display("Saw %0d click reports and %0d hold events, %0d mismatches.",
             click_reports, hold_reports, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
